>>> src/canonical_huffman_table_builder_unit_defines.svh
// Assertion macros for the canonical Huffman table builder.
`ifndef CANONICAL_HUFFMAN_TABLE_BUILDER_UNIT_DEFINES_SVH
`define CANONICAL_HUFFMAN_TABLE_BUILDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define CHTB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// checked on every edge, reset included
`define CHTB_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);
`else
`define CHTB_ASSERT(name, clk, rst, prop, msg)
`define CHTB_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> src/chtb_pkg.sv
package chtb_pkg;

   localparam int TABLE_BITS  = 10;
   localparam int NUM_SYMBOLS = 256;
   localparam int MAX_LEN     = 15;

   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam int SYM_W      = $clog2(NUM_SYMBOLS);
   localparam int LEN_W      = 4;
   localparam int CODE_W     = 16;
   localparam int REV_W      = MAX_LEN;
   localparam int J_W        = MAX_LEN + 2;
   localparam int CNT_W      = $clog2(NUM_SYMBOLS + 1);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] symbol;
      logic [3:0] code_length;
      logic [9:0] table_index;
   } req_type;

   // also the layout of one decode table word
   typedef struct packed {
      logic [7:0] entry_symbol;
      logic [3:0] entry_length;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
      logic [LEN_W-1:0] data;
   } ls_wr_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
   } ls_rd_type;

   typedef struct packed {
      logic                  en;
      logic [TABLE_BITS-1:0] addr;
      rsp_type               data;
   } tbl_wr_type;

   typedef struct packed {
      logic                  en;
      logic [TABLE_BITS-1:0] addr;
   } tbl_rd_type;

   // reverse the low len bits of code
   function automatic logic [REV_W-1:0] reverse_code(input logic [CODE_W-1:0] code,
                                                      input logic [LEN_W-1:0]  len);
      logic [REV_W-1:0] r;
      logic [LEN_W-1:0] src;
      r   = '0;
      src = '0;
      for (int b = 0; b < REV_W; b++) begin
         if (LEN_W'(b) < len) begin
            src  = len - LEN_W'(b) - LEN_W'(1);
            r[b] = code[src];
         end
      end
      return r;
   endfunction

endpackage

>>> src/chtb_len_store.sv
module chtb_len_store (
   input  logic                           clock,
   input  logic                           reset,
   input  chtb_pkg::ls_wr_type            wr,
   input  chtb_pkg::ls_rd_type            rd,
   output logic [chtb_pkg::LEN_W-1:0]     rd_len
);
   import chtb_pkg::*;

   logic [LEN_W-1:0]       mem_ff [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] vld_ff;
   logic [LEN_W-1:0]       q_ff;
   logic                   q_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         q_ff <= mem_ff[rd.addr];
      end
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            q_vld_ff <= vld_ff[rd.addr];
         end
      end
   end

   assign rd_len = q_vld_ff ? q_ff : '0;

endmodule

>>> src/chtb_dec_table.sv
module chtb_dec_table (
   input  logic                 clock,
   input  logic                 reset,
   input  chtb_pkg::tbl_wr_type wr,
   input  chtb_pkg::tbl_rd_type rd,
   output chtb_pkg::rsp_type    rd_data
);
   import chtb_pkg::*;

   rsp_type mem_ff [TABLE_SIZE];
   rsp_type q_ff;
   logic    built_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         q_ff <= mem_ff[rd.addr];
      end
   end

   // every build sweeps the whole table first, so one flag covers reset
   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff <= 1'b0;
      end else if (wr.en) begin
         built_ff <= 1'b1;
      end
   end

   assign rd_data = built_ff ? q_ff : '0;

endmodule

>>> src/chtb_build_ctrl.sv
module chtb_build_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   output chtb_pkg::ls_rd_type         ls_rd,
   input  logic [chtb_pkg::LEN_W-1:0]  ls_len,
   output chtb_pkg::tbl_wr_type        tbl_wr
);
   import chtb_pkg::*;

   typedef enum logic [6:0] {
      B_IDLE     = 7'b0000001,
      B_COUNT    = 7'b0000010,
      B_FIRST    = 7'b0000100,
      B_CLEAR    = 7'b0001000,
      B_FILL_RD  = 7'b0010000,
      B_FILL_LEN = 7'b0100000,
      B_FILL_WR  = 7'b1000000
   } bld_state_type;

   localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(NUM_SYMBOLS - 1);

   bld_state_type         state_ff, state_in;
   logic [SYM_W-1:0]      sym_ff;
   logic                  cnt_pend_ff;
   logic [CNT_W-1:0]      cnt_ff [0:MAX_LEN];
   logic [LEN_W-1:0]      k_ff;
   logic [CODE_W-1:0]     code_ff;
   logic [CODE_W-1:0]     next_ff [0:MAX_LEN];
   logic [TABLE_BITS-1:0] clr_ff;
   logic [J_W-1:0]        j_ff;
   logic [LEN_W-1:0]      len_ff;

   logic [CODE_W-1:0]     code_first;
   logic [REV_W-1:0]      fill_rev;
   logic                  rev_fits;
   logic [J_W-1:0]        j_next;
   logic                  wr_last;

   assign code_first = (code_ff + CODE_W'(cnt_ff[k_ff - LEN_W'(1)])) << 1;
   assign fill_rev   = reverse_code(next_ff[ls_len], ls_len);
   assign rev_fits   = {1'b0, fill_rev} < (REV_W + 1)'(TABLE_SIZE);
   assign j_next     = j_ff + (J_W'(1) << len_ff);
   assign wr_last    = j_next >= J_W'(TABLE_SIZE);
   assign busy       = (state_ff != B_IDLE);

   always_comb begin
      state_in = state_ff;
      ls_rd    = '0;
      tbl_wr   = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               state_in = B_COUNT;
            end
         end
         B_COUNT: begin
            ls_rd.en   = 1'b1;
            ls_rd.addr = sym_ff;
            if (sym_ff == SYM_LAST) begin
               state_in = B_FIRST;
            end
         end
         B_FIRST: begin
            if (k_ff == LEN_W'(MAX_LEN)) begin
               state_in = B_CLEAR;
            end
         end
         B_CLEAR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = clr_ff;
            if (clr_ff == '1) begin
               state_in = B_FILL_RD;
            end
         end
         B_FILL_RD: begin
            ls_rd.en   = 1'b1;
            ls_rd.addr = sym_ff;
            state_in   = B_FILL_LEN;
         end
         B_FILL_LEN: begin
            if (ls_len != '0 && rev_fits) begin
               state_in = B_FILL_WR;
            end else if (sym_ff == SYM_LAST) begin
               state_in = B_IDLE;
            end else begin
               state_in = B_FILL_RD;
            end
         end
         B_FILL_WR: begin
            tbl_wr.en                = 1'b1;
            tbl_wr.addr              = j_ff[TABLE_BITS-1:0];
            tbl_wr.data.entry_symbol = 8'(sym_ff);
            tbl_wr.data.entry_length = len_ff;
            if (wr_last) begin
               state_in = (sym_ff == SYM_LAST) ? B_IDLE : B_FILL_RD;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         cnt_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_pend_ff <= (state_ff == B_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE) begin
         sym_ff <= '0;
      end else if (state_ff == B_COUNT) begin
         sym_ff <= (sym_ff == SYM_LAST) ? '0 : sym_ff + SYM_W'(1);
      end else if (state_in == B_FILL_RD && state_ff != B_CLEAR) begin
         sym_ff <= sym_ff + SYM_W'(1);
      end

      if (state_ff == B_IDLE) begin
         k_ff    <= LEN_W'(1);
         code_ff <= '0;
      end else if (state_ff == B_FIRST) begin
         k_ff    <= k_ff + LEN_W'(1);
         code_ff <= code_first;
      end

      if (state_ff == B_IDLE) begin
         clr_ff <= '0;
      end else if (state_ff == B_CLEAR) begin
         clr_ff <= clr_ff + TABLE_BITS'(1);
      end

      if (state_ff == B_FILL_LEN) begin
         j_ff   <= J_W'(fill_rev);
         len_ff <= ls_len;
      end else if (state_ff == B_FILL_WR) begin
         j_ff <= j_next;
      end
   end

   // length reads are registered, so the last count lands during
   // the first B_FIRST cycle, which only reads the always-zero length 0 slot
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE) begin
         for (int i = 0; i <= MAX_LEN; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_pend_ff && ls_len != '0) begin
         cnt_ff[ls_len] <= cnt_ff[ls_len] + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_FIRST) begin
         next_ff[k_ff] <= code_first;
      end else if (state_ff == B_FILL_LEN && ls_len != '0) begin
         next_ff[ls_len] <= next_ff[ls_len] + CODE_W'(1);
      end
   end

endmodule

>>> src/canonical_huffman_table_builder_unit.sv
// Canonical Huffman decode table builder, LSB-first lookahead. A write stores one symbol's
// code length in a 256 x 4 length memory. A read returns the table entry for the low 10
// index bits; the result is registered in the table, then in the output register. After
// a read the input is held off until the result moves into the output register, and so
// for as long as an earlier result still sits unaccepted there; the next transaction is
// taken while the new result waits. A build walks the memories with a single sequencer:
// it counts the code lengths, computes the first code of each length, clears the table,
// then reads each symbol's length again and writes that symbol's table entries, and
// finally hands back. A complete code fills at most 1024 entries; oversubscribed lengths
// can write up to NUM_SYMBOLS * 512. No transaction is taken until the build finishes.
// Entries read before the first build are zero.
`include "canonical_huffman_table_builder_unit_defines.svh"

module canonical_huffman_table_builder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chtb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output chtb_pkg::rsp_type rsp_data
);
   import chtb_pkg::*;

   typedef enum logic [2:0] {
      T_IDLE  = 3'b001,
      T_READ  = 3'b010,
      T_BUILD = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic          req_fire;
   logic          bld_start;
   logic          bld_busy;
   logic          rsp_load;
   ls_wr_type     ls_wr;
   ls_rd_type     ls_rd;
   logic [LEN_W-1:0] ls_len;
   tbl_wr_type    tbl_wr;
   tbl_rd_type    tbl_rd;
   rsp_type       tbl_q;

   assign req_ready = (state_ff == T_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign bld_start = req_fire && (req_data.command == CMD_BUILD);

   assign ls_wr.en   = req_fire && (req_data.command == CMD_WRITE) &&
                       ({1'b0, req_data.symbol} < 9'(NUM_SYMBOLS));
   assign ls_wr.addr = SYM_W'(req_data.symbol);
   assign ls_wr.data = req_data.code_length;

   assign tbl_rd.en   = req_fire && (req_data.command == CMD_READ);
   assign tbl_rd.addr = TABLE_BITS'(req_data.table_index);

   // table data is held until the output register frees up
   assign rsp_load = (state_ff == T_READ) && (!rsp_valid_ff || rsp_ready);

   chtb_len_store u_len_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (ls_wr),
      .rd     (ls_rd),
      .rd_len (ls_len)
   );

   chtb_dec_table u_dec_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_q)
   );

   chtb_build_ctrl u_build_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (bld_start),
      .busy   (bld_busy),
      .ls_rd  (ls_rd),
      .ls_len (ls_len),
      .tbl_wr (tbl_wr)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (bld_start) begin
               state_in = T_BUILD;
            end else if (tbl_rd.en) begin
               state_in = T_READ;
            end
         end
         T_READ: begin
            if (rsp_load) begin
               state_in = T_IDLE;
            end
         end
         T_BUILD: begin
            if (!bld_busy) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= tbl_q;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CHTB_ASSERT(a_no_accept_in_build, clock, reset, bld_busy |-> !req_ready, "transaction taken during build")
   `CHTB_ASSERT(a_build_starts, clock, reset, bld_start |=> bld_busy, "build did not start")
   `CHTB_ASSERT(a_read_waits, clock, reset, tbl_rd.en |=> (state_ff == T_READ), "read not tracked")
   `CHTB_ASSERT_ALWAYS(a_quiet_after_reset, clock, $past(reset) |-> !rsp_valid, "response after reset")

endmodule
